// ----- src/kwt_pkg.sv -----
package kwt_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int LINE_WIDTH_DEF     = 24;
  localparam int KEY_DEPTH          = 6;
  localparam int OUTQ_DEPTH         = 4;

  localparam logic [4:0] TOK_WHILE  = 5'd0;
  localparam logic [4:0] TOK_IF     = 5'd1;
  localparam logic [4:0] TOK_ELSE   = 5'd2;
  localparam logic [4:0] TOK_PROC   = 5'd3;
  localparam logic [4:0] TOK_FUN    = 5'd4;
  localparam logic [4:0] TOK_DECLR  = 5'd5;
  localparam logic [4:0] TOK_BEGIN  = 5'd6;
  localparam logic [4:0] TOK_END    = 5'd7;
  localparam logic [4:0] TOK_PRINT  = 5'd8;
  localparam logic [4:0] TOK_TYPE   = 5'd9;
  localparam logic [4:0] TOK_IDENT  = 5'd10;
  localparam logic [4:0] TOK_INTLIT = 5'd11;
  localparam logic [4:0] TOK_RPAREN = 5'd12;
  localparam logic [4:0] TOK_LPAREN = 5'd13;
  localparam logic [4:0] TOK_LBRACK = 5'd14;
  localparam logic [4:0] TOK_RBRACK = 5'd15;
  localparam logic [4:0] TOK_SEMI   = 5'd16;
  localparam logic [4:0] TOK_COMMA  = 5'd17;
  localparam logic [4:0] TOK_EQ     = 5'd18;
  localparam logic [4:0] TOK_LT     = 5'd19;
  localparam logic [4:0] TOK_LE     = 5'd20;
  localparam logic [4:0] TOK_GT     = 5'd21;
  localparam logic [4:0] TOK_GE     = 5'd22;
  localparam logic [4:0] TOK_PLUS   = 5'd23;
  localparam logic [4:0] TOK_MINUS  = 5'd24;
  localparam logic [4:0] TOK_STAR   = 5'd25;
  localparam logic [4:0] TOK_SLASH  = 5'd26;
  localparam logic [4:0] TOK_ASSIGN = 5'd27;
  localparam logic [4:0] TOK_COLON  = 5'd28;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";

  typedef struct packed {
    logic       kind;
    logic [7:0] source_byte;
  } item_t;

  typedef struct packed {
    logic [4:0]  token_type;
    logic [23:0] line_number;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   valid0;
    logic   valid1;
    token_t tok0;
    token_t tok1;
  } push_t;

  typedef logic [KEY_DEPTH-1:0][7:0] key_t;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = is_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_pend_char(input logic [7:0] c);
    is_pend_char = c == CH_LT || c == CH_GT || c == CH_COLON || c == CH_SLASH;
  endfunction

  function automatic logic [4:0] pend_type(input logic [7:0] c);
    case (c)
      CH_LT:    pend_type = TOK_LT;
      CH_GT:    pend_type = TOK_GT;
      CH_SLASH: pend_type = TOK_SLASH;
      CH_COLON: pend_type = TOK_COLON;
      default:  pend_type = TOK_IDENT;
    endcase
  endfunction

  function automatic logic [4:0] single_type(input logic [7:0] c);
    case (c)
      CH_RPAREN: single_type = TOK_RPAREN;
      CH_LPAREN: single_type = TOK_LPAREN;
      CH_LBRACK: single_type = TOK_LBRACK;
      CH_RBRACK: single_type = TOK_RBRACK;
      CH_SEMI:   single_type = TOK_SEMI;
      CH_COMMA:  single_type = TOK_COMMA;
      CH_EQ:     single_type = TOK_EQ;
      CH_PLUS:   single_type = TOK_PLUS;
      CH_MINUS:  single_type = TOK_MINUS;
      CH_STAR:   single_type = TOK_STAR;
      default:   single_type = TOK_IDENT;
    endcase
  endfunction

  // word holds the keyword right-aligned, last character in the low byte
  function automatic logic kw_match(input key_t key, input logic [15:0] len,
                                    input logic [47:0] word, input logic [2:0] wlen);
    logic ok;
    int   base;
    ok = (len == {13'd0, wlen});
    for (int i = 0; i < KEY_DEPTH; i++) begin
      base = 8 * (int'(wlen) - 1 - i);
      if (i < int'(wlen) && base >= 0) begin
        if (key[i] != word[base +: 8]) ok = 1'b0;
      end
    end
    kw_match = ok;
  endfunction

  function automatic logic [4:0] word_type(input key_t key, input logic [15:0] len,
                                           input logic letter);
    logic [4:0] t;
    t = letter ? TOK_IDENT : TOK_INTLIT;
    if      (kw_match(key, len, "while",  3'd5)) t = TOK_WHILE;
    else if (kw_match(key, len, "if",     3'd2)) t = TOK_IF;
    else if (kw_match(key, len, "else",   3'd4)) t = TOK_ELSE;
    else if (kw_match(key, len, "proc",   3'd4)) t = TOK_PROC;
    else if (kw_match(key, len, "fun",    3'd3)) t = TOK_FUN;
    else if (kw_match(key, len, "DECLR",  3'd5)) t = TOK_DECLR;
    else if (kw_match(key, len, "BEGIN",  3'd5)) t = TOK_BEGIN;
    else if (kw_match(key, len, "END",    3'd3)) t = TOK_END;
    else if (kw_match(key, len, "print",  3'd5)) t = TOK_PRINT;
    else if (kw_match(key, len, "int",    3'd3)) t = TOK_TYPE;
    else if (kw_match(key, len, "string", 3'd6)) t = TOK_TYPE;
    word_type = t;
  endfunction

endpackage

// ----- src/kwt_lexer.sv -----
module kwt_lexer #(
  parameter int POSITION_WIDTH = kwt_pkg::POSITION_WIDTH_DEF,
  parameter int LINE_WIDTH     = kwt_pkg::LINE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  kwt_pkg::item_t  item,
  output kwt_pkg::push_t  push
);

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_WORD    = 4'b0010,
    MODE_PEND    = 4'b0100,
    MODE_COMMENT = 4'b1000
  } mode_t;

  mode_t                     mode_r, mode_nxt;
  logic [15:0]               word_len_r, word_len_nxt;
  logic [POSITION_WIDTH-1:0] word_start_r, word_start_nxt;
  kwt_pkg::key_t             key_r, key_nxt;
  logic                      letter_r, letter_nxt;
  logic [7:0]                pend_char_r, pend_char_nxt;
  logic [POSITION_WIDTH-1:0] pend_start_r, pend_start_nxt;
  logic [LINE_WIDTH-1:0]     line_r, line_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;

  logic [7:0]                b;
  logic                      do_fresh;
  logic                      pre_v, fr_v;
  logic [4:0]                pre_type, fr_type;
  logic [POSITION_WIDTH-1:0] pre_start;
  logic [15:0]               pre_len;
  logic [63:0]               line_ext, pre_ext, fr_ext;
  logic [23:0]               line_out;
  kwt_pkg::token_t           pre_tok, fr_tok;

  assign b = item.source_byte;

  always_comb begin
    mode_nxt       = mode_r;
    word_len_nxt   = word_len_r;
    word_start_nxt = word_start_r;
    key_nxt        = key_r;
    letter_nxt     = letter_r;
    pend_char_nxt  = pend_char_r;
    pend_start_nxt = pend_start_r;
    line_nxt       = line_r;
    pos_nxt        = pos_r;
    do_fresh       = 1'b0;
    pre_v          = 1'b0;
    pre_type       = kwt_pkg::word_type(key_r, word_len_r, letter_r);
    pre_start      = word_start_r;
    pre_len        = word_len_r;
    fr_v           = 1'b0;
    fr_type        = kwt_pkg::single_type(b);
    if (step) begin
      if (item.kind) begin
        case (mode_r)
          MODE_WORD: pre_v = 1'b1;
          MODE_PEND: begin
            pre_v     = 1'b1;
            pre_type  = kwt_pkg::pend_type(pend_char_r);
            pre_start = pend_start_r;
            pre_len   = 16'd1;
          end
          default: ;
        endcase
        mode_nxt = MODE_IDLE;
      end else begin
        case (mode_r)
          MODE_WORD: begin
            if (kwt_pkg::is_alnum(b)) begin
              if (word_len_r < 16'(kwt_pkg::KEY_DEPTH)) key_nxt[word_len_r[2:0]] = b;
              if (word_len_r != 16'hFFFF) word_len_nxt = word_len_r + 16'd1;
            end else begin
              pre_v    = 1'b1;
              do_fresh = 1'b1;
            end
          end
          MODE_PEND: begin
            pre_start = pend_start_r;
            mode_nxt  = MODE_IDLE;
            if (b == kwt_pkg::CH_EQ && pend_char_r == kwt_pkg::CH_LT) begin
              pre_v    = 1'b1;
              pre_type = kwt_pkg::TOK_LE;
              pre_len  = 16'd2;
            end else if (b == kwt_pkg::CH_EQ && pend_char_r == kwt_pkg::CH_GT) begin
              pre_v    = 1'b1;
              pre_type = kwt_pkg::TOK_GE;
              pre_len  = 16'd2;
            end else if (b == kwt_pkg::CH_EQ && pend_char_r == kwt_pkg::CH_COLON) begin
              pre_v    = 1'b1;
              pre_type = kwt_pkg::TOK_ASSIGN;
              pre_len  = 16'd2;
            end else if (b == kwt_pkg::CH_SLASH && pend_char_r == kwt_pkg::CH_SLASH) begin
              mode_nxt = MODE_COMMENT;
            end else begin
              pre_v    = 1'b1;
              pre_type = kwt_pkg::pend_type(pend_char_r);
              pre_len  = 16'd1;
              do_fresh = 1'b1;
            end
          end
          MODE_COMMENT: begin
            if (b == kwt_pkg::CH_LF) mode_nxt = MODE_IDLE;
          end
          default: do_fresh = 1'b1;
        endcase
        pos_nxt = pos_r + 1'b1;
        if (b == kwt_pkg::CH_LF) line_nxt = line_r + 1'b1;
      end
      if (do_fresh) begin
        mode_nxt = MODE_IDLE;
        if (kwt_pkg::is_space(b)) begin
        end else if (kwt_pkg::is_alnum(b)) begin
          mode_nxt       = MODE_WORD;
          word_start_nxt = pos_r;
          word_len_nxt   = 16'd1;
          key_nxt[0]     = b;
          letter_nxt     = kwt_pkg::is_alpha(b);
        end else if (kwt_pkg::is_pend_char(b)) begin
          mode_nxt       = MODE_PEND;
          pend_char_nxt  = b;
          pend_start_nxt = pos_r;
        end else begin
          fr_v = 1'b1;
        end
      end
    end
  end

  assign line_ext = 64'(line_r);
  assign line_out = line_ext[23:0];
  assign pre_ext  = 64'(pre_start);
  assign fr_ext   = 64'(pos_r);

  always_comb begin
    pre_tok.token_type   = pre_type;
    pre_tok.line_number  = line_out;
    pre_tok.start_offset = pre_ext[31:0];
    pre_tok.token_length = pre_len;
    pre_tok.last         = !fr_v;
    fr_tok.token_type    = fr_type;
    fr_tok.line_number   = line_out;
    fr_tok.start_offset  = fr_ext[31:0];
    fr_tok.token_length  = 16'd1;
    fr_tok.last          = 1'b1;
    push.valid0 = pre_v || fr_v;
    push.valid1 = pre_v && fr_v;
    push.tok0   = pre_v ? pre_tok : fr_tok;
    push.tok1   = fr_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      word_len_r   <= '0;
      word_start_r <= '0;
      letter_r     <= 1'b0;
      pend_char_r  <= '0;
      pend_start_r <= '0;
      line_r       <= '0;
      pos_r        <= '0;
    end else begin
      mode_r       <= mode_nxt;
      word_len_r   <= word_len_nxt;
      word_start_r <= word_start_nxt;
      letter_r     <= letter_nxt;
      pend_char_r  <= pend_char_nxt;
      pend_start_r <= pend_start_nxt;
      line_r       <= line_nxt;
      pos_r        <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- src/kwt_out_fifo.sv -----
module kwt_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  kwt_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output kwt_pkg::token_t out_data
);

  localparam int PTR_W = $clog2(kwt_pkg::OUTQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  kwt_pkg::token_t mem_r [kwt_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_p1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[head_r];
  assign room      = count_r <= CNT_W'(kwt_pkg::OUTQ_DEPTH - 2);
  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + 1'b1;

  always_comb begin
    head_nxt  = pop ? head_r + 1'b1 : head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r - CNT_W'(pop);
    if (push.valid1) begin
      tail_nxt  = tail_r + PTR_W'(2);
      count_nxt = count_nxt + CNT_W'(2);
    end else if (push.valid0) begin
      tail_nxt  = tail_p1;
      count_nxt = count_nxt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) mem_r[tail_r] <= push.tok0;
    if (push.valid1) mem_r[tail_p1] <= push.tok1;
  end

endmodule

// ----- src/keyword_tokenizer_core.sv -----
// Streaming lexer: one source byte (or an end-of-input marker) per transfer,
// one token per transfer out. A byte is taken every clock while the output
// side keeps up; an input transfer reaches its first token through the input
// register, the combinational lexer step and a four-entry token queue. A byte
// that closes a word or a pending operator and is itself a one-character
// token yields two tokens, which enter the queue together and leave one at
// a time; the input stalls only while the queue cannot take two more tokens.
// Tokens carry type, line, start offset and saturating length, and last marks
// the final token caused by an input transfer.
module keyword_tokenizer_core #(
  parameter int POSITION_WIDTH = kwt_pkg::POSITION_WIDTH_DEF,
  parameter int LINE_WIDTH     = kwt_pkg::LINE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  kwt_pkg::item_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output kwt_pkg::token_t out_data
);

  kwt_pkg::item_t item_r;
  logic           item_valid_r, item_valid_nxt;
  logic           room, step;
  kwt_pkg::push_t push;

  assign step     = item_valid_r && room;
  assign in_ready = !item_valid_r || step;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_valid && in_ready) item_valid_nxt = 1'b1;
    else if (step) item_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
  end

  kwt_lexer #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LINE_WIDTH     (LINE_WIDTH)
  ) u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .push  (push)
  );

  kwt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
